// ----- rtl/fsr_pkg.sv -----
// Shared types and codes for the four-axis setpoint ramp.
package fsr_pkg;

  localparam int NUM_AXES = 4;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_INDEX_BITS = 3;
  localparam int MASK_BITS = 16;
  localparam int FIELD_BITS = 16;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SET   = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_code_t;

  typedef enum logic [1:0] {
    SEND_NONE  = 2'd0,
    SEND_BODY  = 2'd1,
    SEND_VALUE = 2'd2
  } send_kind_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_INIT = 3'd0,
    REG_MAX  = 3'd1,
    REG_MIN  = 3'd2,
    REG_STEP = 3'd3,
    REG_MASK = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0]                   command;
    logic signed [FIELD_BITS-1:0] target_x;
    logic signed [FIELD_BITS-1:0] target_y;
    logic signed [FIELD_BITS-1:0] target_z;
    logic signed [FIELD_BITS-1:0] target_theta;
    logic [3:0]                   walk_mode;
    logic [3:0]                   sensor_select;
  } cmd_word_t;

  typedef struct packed {
    logic                         accepted;
    logic [1:0]                   send_kind;
    logic signed [FIELD_BITS-1:0] pos_x;
    logic signed [FIELD_BITS-1:0] pos_y;
    logic signed [FIELD_BITS-1:0] pos_z;
    logic signed [FIELD_BITS-1:0] pos_theta;
    logic [3:0]                   mode_out;
    logic [3:0]                   sensor_out;
  } res_word_t;

  typedef struct packed {
    logic       running;
    logic       target_valid;
    logic [3:0] stored_mode;
    logic [3:0] stored_sensor;
  } ctl_state_t;

  // Per-lane control strobes from the top level.
  typedef struct packed {
    logic step;
    logic tgt_write;
    logic tgt_from_req;
    logic load;
  } lane_ctrl_t;

  // Per-lane status toward the merge stage.
  typedef struct packed {
    logic same;
    logic bad;
  } lane_stat_t;

  // What the merge stage decided for the current word.
  typedef struct packed {
    logic tick_ok;
    logic tgt_write;
    logic tgt_from_req;
    logic tv_set;
    logic start_ok;
    logic stop_ok;
  } decision_t;

endpackage

// ----- rtl/fsr_channels.sv -----
// Handshake channels of the setpoint ramp: command, result and configuration.
interface fsr_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [15:0] target_x;
  logic signed [15:0] target_y;
  logic signed [15:0] target_z;
  logic signed [15:0] target_theta;
  logic [3:0]        walk_mode;
  logic [3:0]        sensor_select;

  modport source (output valid, command, target_x, target_y, target_z, target_theta,
                  walk_mode, sensor_select, input ready);
  modport sink (input valid, command, target_x, target_y, target_z, target_theta,
                walk_mode, sensor_select, output ready);
endinterface

interface fsr_res_if;
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [1:0]        send_kind;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] pos_theta;
  logic [3:0]        mode_out;
  logic [3:0]        sensor_out;

  modport source (output valid, accepted, send_kind, pos_x, pos_y, pos_z, pos_theta,
                  mode_out, sensor_out, input ready);
  modport sink (input valid, accepted, send_kind, pos_x, pos_y, pos_z, pos_theta,
                mode_out, sensor_out, output ready);
endinterface

interface fsr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/four_axis_setpoint_ramp_core.sv -----
// Top level of the four-axis setpoint ramp: lanes, merge, control state and output skid.
//
//  channel  dir  handshake          payload
//  cfg      in   cfg.valid/ready    index (register 0..4), data (64 bits)
//  cmd      in   cmd.valid/ready    command, target_x/y/z/theta, walk_mode, sensor_select
//  res      out  res.valid/ready    accepted, send_kind, pos_x/y/z/theta, mode_out, sensor_out
//
// For every command word the four lanes step, clamp and check limits in
// parallel, the merge stage reduces their flags, and the result is registered.
// One word per cycle is sustained while the skid is not full; the output register plus a one-word skid let a
// new word enter while a finished result still waits on res.ready.
// Reset (rst, synchronous) clears positions, targets, running, target_valid, the stored
// modes and all configuration registers; cfg.ready is always high.
// A stalled result holds in the output register; cmd.ready drops only while the skid is full.
module four_axis_setpoint_ramp_core
  import fsr_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  fsr_cfg_if.sink    cfg,
  fsr_cmd_if.sink    cmd,
  fsr_res_if.source  res
);

  localparam int VB = VALUE_BITS;
  localparam int EXT_BITS = 32;

  // Take lane n of a packed register; lanes past bit 63 read as zero.
  function automatic logic [VB-1:0] lane_of(input logic [CFG_DATA_BITS-1:0] r,
                                            input int n);
    logic [CFG_DATA_BITS-1:0] s;
    s = r >> (n * VB);
    return s[VB-1:0];
  endfunction

  // Zero-extend a 16-bit field and keep its low VB bits, as the lanes see it.
  function automatic logic [VB-1:0] req_of(input logic [FIELD_BITS-1:0] f);
    logic [EXT_BITS-1:0] e;
    e = {{(EXT_BITS - FIELD_BITS){1'b0}}, f};
    return e[VB-1:0];
  endfunction

  // Configuration registers.
  logic [CFG_DATA_BITS-1:0] init_values;
  logic [CFG_DATA_BITS-1:0] max_values;
  logic [CFG_DATA_BITS-1:0] min_values;
  logic [CFG_DATA_BITS-1:0] step_values;
  logic [MASK_BITS-1:0]     continuous_mode_mask;

  ctl_state_t st;
  cmd_word_t  cmd_word;
  decision_t  dec;
  res_word_t  res_new;

  logic       cfg_wr;
  logic       cfg_init_wr;
  logic       acc_in;
  logic       drain;

  lane_ctrl_t           lane_ctrl;
  lane_stat_t           stat    [NUM_AXES];
  logic signed [VB-1:0] pos_cur [NUM_AXES];
  logic signed [VB-1:0] pos_new [NUM_AXES];
  logic signed [VB-1:0] init_l  [NUM_AXES];
  logic signed [VB-1:0] max_l   [NUM_AXES];
  logic signed [VB-1:0] min_l   [NUM_AXES];
  logic        [VB-1:0] step_l  [NUM_AXES];
  logic signed [VB-1:0] req_l   [NUM_AXES];
  logic signed [VB-1:0] load_l  [NUM_AXES];

  // Output register and skid.
  logic      out_valid;
  res_word_t out_data;
  logic      skid_valid;
  res_word_t skid_data;

  assign cfg.ready   = 1'b1;
  assign cfg_wr      = cfg.valid && cfg.ready;
  assign cfg_init_wr = cfg_wr && (cfg_reg_t'(cfg.index) == REG_INIT);

  assign cmd.ready = !skid_valid;
  assign acc_in    = cmd.valid && cmd.ready;
  assign drain     = out_valid && res.ready;

  assign cmd_word.command       = cmd.command;
  assign cmd_word.target_x      = cmd.target_x;
  assign cmd_word.target_y      = cmd.target_y;
  assign cmd_word.target_z      = cmd.target_z;
  assign cmd_word.target_theta  = cmd.target_theta;
  assign cmd_word.walk_mode     = cmd.walk_mode;
  assign cmd_word.sensor_select = cmd.sensor_select;

  assign req_l[0] = req_of(cmd.target_x);
  assign req_l[1] = req_of(cmd.target_y);
  assign req_l[2] = req_of(cmd.target_z);
  assign req_l[3] = req_of(cmd.target_theta);

  // Lane strobes: only act on an accepted word; an idle init write reloads positions.
  assign lane_ctrl.step         = acc_in && dec.tick_ok;
  assign lane_ctrl.tgt_write    = acc_in && dec.tgt_write;
  assign lane_ctrl.tgt_from_req = dec.tgt_from_req;
  assign lane_ctrl.load         = (acc_in && (dec.start_ok || dec.stop_ok)) ||
                                  (cfg_init_wr && !st.running);

  for (genvar n = 0; n < NUM_AXES; n++) begin : g_lane
    assign init_l[n] = lane_of(init_values, n);
    assign max_l[n]  = lane_of(max_values, n);
    assign min_l[n]  = lane_of(min_values, n);
    assign step_l[n] = lane_of(step_values, n);
    assign load_l[n] = cfg_init_wr ? lane_of(cfg.data, n) : init_l[n];

    fsr_lane #(
      .VB (VB)
    ) u_lane (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (lane_ctrl),
      .req      (req_l[n]),
      .init_l   (init_l[n]),
      .max_l    (max_l[n]),
      .min_l    (min_l[n]),
      .step_l   (step_l[n]),
      .load_val (load_l[n]),
      .pos_q    (pos_cur[n]),
      .pos_step (pos_new[n]),
      .stat     (stat[n])
    );
  end

  fsr_merge #(
    .VB (VB)
  ) u_merge (
    .cmd_word  (cmd_word),
    .st        (st),
    .mode_mask (continuous_mode_mask),
    .stat      (stat),
    .pos_cur   (pos_cur),
    .pos_new   (pos_new),
    .init_l    (init_l),
    .dec       (dec),
    .res       (res_new)
  );

  // Configuration registers: take every write, drop unknown indexes.
  always_ff @(posedge clk) begin
    if (rst) begin
      init_values          <= '0;
      max_values           <= '0;
      min_values           <= '0;
      step_values          <= '0;
      continuous_mode_mask <= '0;
    end else if (cfg_wr) begin
      unique case (cfg.index)
        REG_INIT: init_values          <= cfg.data;
        REG_MAX:  max_values           <= cfg.data;
        REG_MIN:  min_values           <= cfg.data;
        REG_STEP: step_values          <= cfg.data;
        REG_MASK: continuous_mode_mask <= cfg.data[MASK_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Control state: start always latches the modes; running follows start and stop; a set marks the target valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (acc_in) begin
      if (cmd_code_t'(cmd.command) == CMD_START) begin
        st.stored_mode   <= cmd.walk_mode;
        st.stored_sensor <= cmd.sensor_select;
      end
      if (dec.tv_set) begin
        st.target_valid <= 1'b1;
      end
      if (dec.start_ok) begin
        st.running <= 1'b1;
      end else if (dec.stop_ok) begin
        st.running <= 1'b0;
      end
    end
  end

  // Output register with one-word skid.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (drain) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        skid_valid <= 1'b0;
      end else if (acc_in) begin
        out_data <= res_new;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (acc_in) begin
      if (!out_valid) begin
        out_data  <= res_new;
        out_valid <= 1'b1;
      end else begin
        skid_data  <= res_new;
        skid_valid <= 1'b1;
      end
    end
  end

  assign res.valid      = out_valid;
  assign res.accepted   = out_data.accepted;
  assign res.send_kind  = out_data.send_kind;
  assign res.pos_x      = out_data.pos_x;
  assign res.pos_y      = out_data.pos_y;
  assign res.pos_z      = out_data.pos_z;
  assign res.pos_theta  = out_data.pos_theta;
  assign res.mode_out   = out_data.mode_out;
  assign res.sensor_out = out_data.sensor_out;

  // A full skid always sits behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid holds a word while the output register is empty");

  // A successful start leaves the block running.
  a_start_runs: assert property (@(posedge clk) disable iff (rst)
    (acc_in && dec.start_ok) |=> st.running)
    else $error("start accepted but block not running");

  // A successful stop leaves the block idle.
  a_stop_idles: assert property (@(posedge clk) disable iff (rst)
    (acc_in && dec.stop_ok) |=> !st.running)
    else $error("stop accepted but block still running");

  // Continuous values never carry a walking mode.
  a_value_no_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.send_kind == SEND_VALUE) |-> (out_data.mode_out == '0))
    else $error("continuous value carries a walking mode");

  // Results with something sent were accepted.
  a_sent_accepted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.send_kind != SEND_NONE) |-> out_data.accepted)
    else $error("sent result not marked accepted");

endmodule

// ----- rtl/fsr_lane.sv -----
// One axis lane: position and target registers, step, clamp and limit check.
module fsr_lane
  import fsr_pkg::*;
#(
  parameter int VB = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lane_ctrl_t           ctrl,
  input  logic signed [VB-1:0] req,
  input  logic signed [VB-1:0] init_l,
  input  logic signed [VB-1:0] max_l,
  input  logic signed [VB-1:0] min_l,
  input  logic        [VB-1:0] step_l,
  input  logic signed [VB-1:0] load_val,
  output logic signed [VB-1:0] pos_q,
  output logic signed [VB-1:0] pos_step,
  output lane_stat_t           stat
);

  localparam int W = VB + 2;

  logic signed [VB-1:0] tgt;
  logic signed [VB-1:0] tgt_src;
  logic signed [VB-1:0] tgt_clamped;
  logic signed [W-1:0]  v_w;
  logic signed [W-1:0]  e_w;
  logic signed [W-1:0]  one_w;
  logic signed [W-1:0]  lo_w;
  logic signed [W-1:0]  hi_w;
  logic signed [W-1:0]  up_w;
  logic signed [W-1:0]  dn_w;

  assign v_w   = W'(pos_q);
  assign e_w   = W'(tgt);
  assign one_w = $signed({2'b00, step_l});
  assign lo_w  = e_w - one_w;
  assign hi_w  = e_w + one_w;
  assign up_w  = v_w + one_w;
  assign dn_w  = v_w - one_w;

  // Move one step toward the target, snap once within a step.
  always_comb begin
    if (v_w < lo_w) begin
      pos_step = up_w[VB-1:0];
    end else if (v_w > hi_w) begin
      pos_step = dn_w[VB-1:0];
    end else begin
      pos_step = tgt;
    end
  end

  assign tgt_src = ctrl.tgt_from_req ? req : tgt;

  always_comb begin
    if (tgt_src < min_l) begin
      tgt_clamped = min_l;
    end else if (tgt_src > max_l) begin
      tgt_clamped = max_l;
    end else begin
      tgt_clamped = tgt_src;
    end
  end

  assign stat.same = (req == tgt);
  assign stat.bad  = (max_l < min_l) || (init_l < min_l) || (init_l > max_l);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_q <= '0;
      tgt   <= '0;
    end else begin
      if (ctrl.load) begin
        pos_q <= load_val;
      end else if (ctrl.step) begin
        pos_q <= pos_step;
      end
      if (ctrl.tgt_write) begin
        tgt <= tgt_clamped;
      end
    end
  end

endmodule

// ----- rtl/fsr_merge.sv -----
// Merge stage: combine lane status, decide the command and build the result word.
module fsr_merge
  import fsr_pkg::*;
#(
  parameter int VB = 16
) (
  input  cmd_word_t            cmd_word,
  input  ctl_state_t           st,
  input  logic [MASK_BITS-1:0] mode_mask,
  input  lane_stat_t           stat [NUM_AXES],
  input  logic signed [VB-1:0] pos_cur [NUM_AXES],
  input  logic signed [VB-1:0] pos_new [NUM_AXES],
  input  logic signed [VB-1:0] init_l [NUM_AXES],
  output decision_t            dec,
  output res_word_t            res
);

  logic                  all_same;
  logic                  any_bad;
  logic                  cont_new;
  logic                  cont_stored;
  logic signed [VB-1:0]  pv [NUM_AXES];
  logic signed [31:0]    pv_w [NUM_AXES];

  always_comb begin
    all_same = 1'b1;
    any_bad  = 1'b0;
    for (int n = 0; n < NUM_AXES; n++) begin
      all_same = all_same & stat[n].same;
      any_bad  = any_bad | stat[n].bad;
    end
  end

  assign cont_new    = mode_mask[cmd_word.walk_mode];
  assign cont_stored = mode_mask[st.stored_mode];

  always_comb begin
    dec = '0;
    res = '0;
    for (int n = 0; n < NUM_AXES; n++) begin
      pv[n] = '0;
    end
    unique case (cmd_code_t'(cmd_word.command))
      CMD_TICK: begin
        if (st.running) begin
          dec.tick_ok    = 1'b1;
          res.accepted   = 1'b1;
          res.send_kind  = SEND_VALUE;
          res.sensor_out = st.stored_sensor;
          pv             = pos_new;
        end
      end
      CMD_SET: begin
        if (all_same && st.target_valid) begin
          res.accepted = 1'b1;
        end else begin
          dec.tgt_write    = 1'b1;
          dec.tgt_from_req = 1'b1;
          dec.tv_set       = 1'b1;
          res.accepted     = !any_bad;
        end
      end
      CMD_START: begin
        if (cont_new && !st.running) begin
          dec.tgt_write = 1'b1;
          if (!any_bad && st.target_valid) begin
            dec.start_ok   = 1'b1;
            res.accepted   = 1'b1;
            res.send_kind  = SEND_BODY;
            res.mode_out   = cmd_word.walk_mode;
            res.sensor_out = cmd_word.sensor_select;
            pv             = init_l;
          end
        end
      end
      CMD_STOP: begin
        if (cont_stored && st.running) begin
          dec.stop_ok    = 1'b1;
          res.accepted   = 1'b1;
          res.send_kind  = SEND_BODY;
          res.mode_out   = st.stored_mode;
          res.sensor_out = st.stored_sensor;
          pv             = pos_cur;
        end
      end
      default: begin
      end
    endcase
    // Report the low 16 bits of each sign-extended lane value.
    for (int n = 0; n < NUM_AXES; n++) begin
      pv_w[n] = 32'(pv[n]);
    end
    res.pos_x     = pv_w[0][FIELD_BITS-1:0];
    res.pos_y     = pv_w[1][FIELD_BITS-1:0];
    res.pos_z     = pv_w[2][FIELD_BITS-1:0];
    res.pos_theta = pv_w[3][FIELD_BITS-1:0];
  end

endmodule

// ----- sim/four_axis_setpoint_ramp_checker.sv -----
// Watches the channels of the setpoint ramp, predicts every result word and compares it.
`timescale 1ns / 100ps

module four_axis_setpoint_ramp_checker
  import fsr_pkg::*;
#(
  parameter int VALUE_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  fsr_cfg_if          cfg,
  fsr_cmd_if          cmd,
  fsr_res_if          res,
  output int unsigned outstanding,
  output int unsigned fail_count
);

  // Register copies.
  logic [63:0] init_lanes, max_lanes, min_lanes, step_lanes;
  logic [15:0] walk_mask;

  // Ramp state.
  longint      pos[NUM_AXES];
  longint      tgt[NUM_AXES];
  bit          running, tgt_valid;
  logic [3:0]  mode_q, sensor_q;

  res_word_t   due_words[$];
  int unsigned res_seen;

  initial begin
    outstanding = 0;
    fail_count = 0;
    res_seen = 0;
  end

  function automatic longint unsigned lane_bits(input logic [63:0] packed_reg, input int n);
    int              sh = n * VALUE_BITS;
    longint unsigned m = (64'd1 << VALUE_BITS) - 64'd1;
    if (sh >= 64) return 0;
    return (packed_reg >> sh) & m;
  endfunction

  function automatic longint lane_signed(input longint unsigned v);
    longint unsigned m = (64'd1 << VALUE_BITS) - 64'd1;
    v &= m;
    if (v[VALUE_BITS-1]) return longint'(v) - longint'(m + 64'd1);
    return longint'(v);
  endfunction

  function automatic void load_start();
    for (int n = 0; n < NUM_AXES; n++) pos[n] = lane_signed(lane_bits(init_lanes, n));
  endfunction

  // Check limits and clamp every target into [min,max].
  function automatic bit limits_ok();
    bit     ok = 1'b1;
    longint mx, mn, iv;
    for (int n = 0; n < NUM_AXES; n++) begin
      mx = lane_signed(lane_bits(max_lanes, n));
      mn = lane_signed(lane_bits(min_lanes, n));
      iv = lane_signed(lane_bits(init_lanes, n));
      if (mx < mn) ok = 1'b0;
      if (iv < mn || iv > mx) ok = 1'b0;
      if (tgt[n] < mn) tgt[n] = mn;
      else if (tgt[n] > mx) tgt[n] = mx;
    end
    return ok;
  endfunction

  function automatic res_word_t predict_ramp(input cmd_word_t w);
    res_word_t   r;
    logic [15:0] raw[NUM_AXES];
    longint      req[NUM_AXES];
    longint      sent[NUM_AXES];
    longint      one;
    bit          same;
    r = '0;
    same = 1'b1;
    raw[0] = w.target_x;
    raw[1] = w.target_y;
    raw[2] = w.target_z;
    raw[3] = w.target_theta;
    for (int n = 0; n < NUM_AXES; n++) sent[n] = 0;
    case (w.command)
      CMD_TICK: begin
        if (running) begin
          for (int n = 0; n < NUM_AXES; n++) begin
            one = longint'(lane_bits(step_lanes, n));
            if (pos[n] < tgt[n] - one) pos[n] += one;
            else if (pos[n] > tgt[n] + one) pos[n] -= one;
            else pos[n] = tgt[n];
            sent[n] = pos[n];
          end
          r.accepted = 1'b1;
          r.send_kind = SEND_VALUE;
          r.sensor_out = sensor_q;
        end
      end
      CMD_SET: begin
        for (int n = 0; n < NUM_AXES; n++) begin
          req[n] = lane_signed({48'd0, raw[n]});
          if (req[n] != tgt[n]) same = 1'b0;
        end
        if (same && tgt_valid) begin
          r.accepted = 1'b1;
        end else begin
          for (int n = 0; n < NUM_AXES; n++) tgt[n] = req[n];
          tgt_valid = 1'b1;
          r.accepted = limits_ok();
        end
      end
      CMD_START: begin
        mode_q = w.walk_mode;
        sensor_q = w.sensor_select;
        if (walk_mask[mode_q] && !running) begin
          if (limits_ok() && tgt_valid) begin
            load_start();
            for (int n = 0; n < NUM_AXES; n++) sent[n] = pos[n];
            running = 1'b1;
            r.accepted = 1'b1;
            r.send_kind = SEND_BODY;
            r.mode_out = mode_q;
            r.sensor_out = sensor_q;
          end
        end
      end
      default: begin
        if (walk_mask[mode_q] && running) begin
          for (int n = 0; n < NUM_AXES; n++) sent[n] = pos[n];
          running = 1'b0;
          load_start();
          r.accepted = 1'b1;
          r.send_kind = SEND_BODY;
          r.mode_out = mode_q;
          r.sensor_out = sensor_q;
        end
      end
    endcase
    r.pos_x = sent[0][15:0];
    r.pos_y = sent[1][15:0];
    r.pos_z = sent[2][15:0];
    r.pos_theta = sent[3][15:0];
    return r;
  endfunction

  always @(posedge clk) begin
    cmd_word_t w;
    res_word_t got, want;
    bit        differs;
    if (rst) begin
      init_lanes = '0;
      max_lanes = '0;
      min_lanes = '0;
      step_lanes = '0;
      walk_mask = '0;
      for (int n = 0; n < NUM_AXES; n++) begin
        pos[n] = 0;
        tgt[n] = 0;
      end
      running = 1'b0;
      tgt_valid = 1'b0;
      mode_q = '0;
      sensor_q = '0;
      due_words.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_INIT: begin
            init_lanes = cfg.data;
            if (!running) load_start();
          end
          REG_MAX:  max_lanes = cfg.data;
          REG_MIN:  min_lanes = cfg.data;
          REG_STEP: step_lanes = cfg.data;
          REG_MASK: walk_mask = cfg.data[15:0];
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        w.command = cmd.command;
        w.target_x = cmd.target_x;
        w.target_y = cmd.target_y;
        w.target_z = cmd.target_z;
        w.target_theta = cmd.target_theta;
        w.walk_mode = cmd.walk_mode;
        w.sensor_select = cmd.sensor_select;
        due_words.push_back(predict_ramp(w));
      end
      if (res.valid && res.ready) begin
        got.accepted = res.accepted;
        got.send_kind = res.send_kind;
        got.pos_x = res.pos_x;
        got.pos_y = res.pos_y;
        got.pos_z = res.pos_z;
        got.pos_theta = res.pos_theta;
        got.mode_out = res.mode_out;
        got.sensor_out = res.sensor_out;
        if (due_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: result word %0d arrived with nothing pending", $time, res_seen);
        end else begin
          want = due_words.pop_front();
          differs = (got.accepted !== want.accepted) || (got.send_kind !== want.send_kind) ||
                    (got.pos_x !== want.pos_x) || (got.pos_y !== want.pos_y) ||
                    (got.pos_z !== want.pos_z) || (got.pos_theta !== want.pos_theta) ||
                    (got.mode_out !== want.mode_out) || (got.sensor_out !== want.sensor_out);
          if (differs) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t: result word %0d mismatch", $time, res_seen);
              $display("  exp acc=%0d kind=%0d x=%0d y=%0d z=%0d th=%0d mode=%0d sens=%0d",
                       want.accepted, want.send_kind, want.pos_x, want.pos_y, want.pos_z,
                       want.pos_theta, want.mode_out, want.sensor_out);
              $display("  got acc=%0d kind=%0d x=%0d y=%0d z=%0d th=%0d mode=%0d sens=%0d",
                       got.accepted, got.send_kind, got.pos_x, got.pos_y, got.pos_z,
                       got.pos_theta, got.mode_out, got.sensor_out);
            end
          end
        end
        res_seen++;
      end
    end
    outstanding = due_words.size();
  end

endmodule

// ----- sim/four_axis_setpoint_ramp_core_test.sv -----
// Stimulus and verdict for the four-axis setpoint ramp core.
`timescale 1ns / 100ps

module four_axis_setpoint_ramp_core_test
  import fsr_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no handshake on any channel
  localparam int LONG_HOLD      = 400;   // result-side hold that backs the block up
  localparam int DRAIN_CYCLES   = 10;    // quiet cycles after the last result
  localparam int BURST_WORDS    = 100;   // random words per register setting

  // How a register setting is shaped.
  typedef enum int {
    LIMITS_RANDOM,
    LIMITS_WIDEST,
    LIMITS_BROKEN,
    LIMITS_RAW
  } limit_style_t;

  logic clk = 1'b0;
  logic rst;

  fsr_cfg_if cfg_ch ();
  fsr_cmd_if cmd_ch ();
  fsr_res_if res_ch ();

  int unsigned outstanding;
  int unsigned fail_count;

  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  bit          hold_request = 1'b0;
  int          words_sent = 0;
  int          idle_cycles = 0;

  // Limits and mask currently programmed, used to aim targets and pick modes.
  int          lim_lo[NUM_AXES];
  int          lim_hi[NUM_AXES];
  logic [15:0] cont_mask = '0;

  four_axis_setpoint_ramp_core #(
    .VALUE_BITS(16)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  four_axis_setpoint_ramp_checker #(
    .VALUE_BITS(16)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .cfg(cfg_ch),
    .cmd(cmd_ch),
    .res(res_ch),
    .outstanding(outstanding),
    .fail_count(fail_count)
  );

  always #5 clk = ~clk;

  // Watchdog: end the run once no word has moved on any channel for too long.
  always @(posedge clk) begin
    if ((cfg_ch.valid && cfg_ch.ready) || (cmd_ch.valid && cmd_ch.ready) ||
        (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: drop ready at random, or hold it low for a long stretch on request
  // so the output register and skid fill and cmd.ready falls.
  initial begin
    int hold_left;
    hold_left = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = LONG_HOLD;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  function automatic logic [63:0] pack_lanes(input int x, input int y, input int z,
                                             input int th);
    return {16'(th), 16'(z), 16'(y), 16'(x)};
  endfunction

  function automatic int rand_q12_4();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Pick a value in [a,b] either way round, landing on an end now and then.
  function automatic int pick_between(input int a, input int b);
    int lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    case ($urandom_range(0, 9))
      0: return lo;
      1: return hi;
      default: return lo + int'($urandom_range(0, hi - lo));
    endcase
  endfunction

  function automatic logic [3:0] pick_walk_mode(input bit want_continuous);
    logic [3:0] m;
    m = 4'($urandom);
    if (want_continuous && cont_mask != '0) begin
      while (!cont_mask[m]) m = 4'($urandom);
    end
    return m;
  endfunction

  function automatic cmd_word_t random_word(input logic [1:0] c);
    cmd_word_t w;
    w.command = c;
    w.target_x = 16'($urandom);
    w.target_y = 16'($urandom);
    w.target_z = 16'($urandom);
    w.target_theta = 16'($urandom);
    w.walk_mode = 4'($urandom);
    w.sensor_select = 4'($urandom);
    return w;
  endfunction

  // Aim every axis inside the programmed limits so ramps really run.
  function automatic cmd_word_t with_reachable_target(input cmd_word_t w);
    w.target_x = 16'(pick_between(lim_lo[0], lim_hi[0]));
    w.target_y = 16'(pick_between(lim_lo[1], lim_hi[1]));
    w.target_z = 16'(pick_between(lim_lo[2], lim_hi[2]));
    w.target_theta = 16'(pick_between(lim_lo[3], lim_hi[3]));
    return w;
  endfunction

  // Offer one command word, idling first at random; called at a falling edge and
  // returns at the falling edge after the word is taken. Valid stays high on return
  // so back-to-back words go out without a gap.
  task automatic send_word(input cmd_word_t w);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= w.command;
    cmd_ch.target_x <= w.target_x;
    cmd_ch.target_y <= w.target_y;
    cmd_ch.target_z <= w.target_z;
    cmd_ch.target_theta <= w.target_theta;
    cmd_ch.walk_mode <= w.walk_mode;
    cmd_ch.sensor_select <= w.sensor_select;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic issue(input logic [1:0] c, input int x, input int y, input int z,
                       input int th, input int mode, input int sensor);
    cmd_word_t w;
    w.command = c;
    w.target_x = 16'(x);
    w.target_y = 16'(y);
    w.target_z = 16'(z);
    w.target_theta = 16'(th);
    w.walk_mode = 4'(mode);
    w.sensor_select = 4'(sensor);
    send_word(w);
  endtask

  // Write one register; valid is left high for the next write in the group.
  task automatic cfg_write(input logic [2:0] idx, input logic [63:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // Program all five registers, sometimes also an index past the list, then drop valid.
  task automatic apply_settings(input logic [63:0] iv, input logic [63:0] hv,
                                input logic [63:0] lv, input logic [63:0] sv,
                                input logic [15:0] mv);
    cfg_write(REG_INIT, iv);
    cfg_write(REG_MAX, hv);
    cfg_write(REG_MIN, lv);
    cfg_write(REG_STEP, sv);
    cfg_write(REG_MASK, {48'($urandom), mv});
    if ($urandom_range(0, 3) == 0)
      cfg_write(3'(REG_MASK) + 3'($urandom_range(1, 3)), {$urandom, $urandom});
    cfg_ch.valid <= 1'b0;
    for (int n = 0; n < NUM_AXES; n++) begin
      lim_lo[n] = int'($signed(lv[16*n +: 16]));
      lim_hi[n] = int'($signed(hv[16*n +: 16]));
    end
    cont_mask = mv;
  endtask

  task automatic choose_settings(input limit_style_t style);
    int          lo_v[NUM_AXES], hi_v[NUM_AXES], in_v[NUM_AXES], st_v[NUM_AXES];
    int          a, b, n;
    logic [15:0] mv;
    for (n = 0; n < NUM_AXES; n++) begin
      a = rand_q12_4();
      b = rand_q12_4();
      lo_v[n] = (a < b) ? a : b;
      hi_v[n] = (a < b) ? b : a;
      in_v[n] = pick_between(lo_v[n], hi_v[n]);
      case ($urandom_range(0, 9))
        0: st_v[n] = 0;
        1: st_v[n] = 65535;
        default: st_v[n] = (hi_v[n] - lo_v[n]) / int'($urandom_range(2, 40));
      endcase
    end
    mv = 16'($urandom) | (16'd1 << $urandom_range(0, 15));
    if (style == LIMITS_BROKEN) begin
      // Push one init outside its range, and sometimes invert another axis's limits.
      n = $urandom_range(0, NUM_AXES - 1);
      if (lo_v[n] > -32768 && $urandom_range(0, 1)) in_v[n] = lo_v[n] - 1;
      else if (hi_v[n] < 32767) in_v[n] = hi_v[n] + 1;
      else in_v[n] = lo_v[n] - 1;
      if ($urandom_range(0, 2) == 0) begin
        n = (n + 1) % NUM_AXES;
        a = lo_v[n];
        lo_v[n] = hi_v[n];
        hi_v[n] = a;
      end
    end
    case (style)
      LIMITS_WIDEST:
        apply_settings(pack_lanes(-32768, 32767, 0, -1), pack_lanes(32767, 32767, 32767, 32767),
                       pack_lanes(-32768, -32768, -32768, -32768),
                       pack_lanes(65535, 0, 1, 32768), 16'hFFFF);
      LIMITS_RAW:
        apply_settings({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, $urandom_range(0, 1) ? 16'($urandom) : 16'h0000);
      default:
        apply_settings(pack_lanes(in_v[0], in_v[1], in_v[2], in_v[3]),
                       pack_lanes(hi_v[0], hi_v[1], hi_v[2], hi_v[3]),
                       pack_lanes(lo_v[0], lo_v[1], lo_v[2], lo_v[3]),
                       pack_lanes(st_v[0], st_v[1], st_v[2], st_v[3]), mv);
    endcase
  endtask

  // Set a target, start, tick a while (retargeting now and then), usually stop.
  task automatic ramp_burst();
    cmd_word_t w;
    int        ticks;
    w = random_word(CMD_SET);
    if ($urandom_range(0, 99) < 85) w = with_reachable_target(w);
    send_word(w);
    if ($urandom_range(0, 3) == 0) send_word(w);
    w = random_word(CMD_START);
    w.walk_mode = pick_walk_mode($urandom_range(0, 9) != 0);
    send_word(w);
    ticks = $urandom_range(1, 30);
    repeat (ticks) begin
      if ($urandom_range(0, 9) == 0) w = with_reachable_target(random_word(CMD_SET));
      else w = random_word(CMD_TICK);
      send_word(w);
    end
    if ($urandom_range(0, 9) != 0) send_word(random_word(CMD_STOP));
  endtask

  // Stop offering and wait until every predicted result word has come back.
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    int goal;
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.command <= CMD_TICK;
    cmd_ch.target_x <= '0;
    cmd_ch.target_y <= '0;
    cmd_ch.target_z <= '0;
    cmd_ch.target_theta <= '0;
    cmd_ch.walk_mode <= '0;
    cmd_ch.sensor_select <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_INIT;
    cfg_ch.data <= '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Modes 0, 2 and 15 are continuous; z has a zero step, so once its
    // target lies beyond it the z position must not move.
    src_idle_pct = 36;
    sink_idle_pct = 79;
    apply_settings(pack_lanes(0, -100, 100, 0), pack_lanes(32767, 32767, 32767, 32767),
                   pack_lanes(-32768, -32768, -32768, -32768),
                   pack_lanes(16, 65535, 0, 1), 16'h8005);
    issue(CMD_TICK, 0, 0, 0, 0, 0, 0);                // tick while idle
    issue(CMD_STOP, 0, 0, 0, 0, 0, 0);                // stop while idle
    issue(CMD_START, 0, 0, 0, 0, 2, 4);               // start before any target
    issue(CMD_SET, 32767, -32768, 0, -1, 0, 0);       // extreme targets
    issue(CMD_SET, 32767, -32768, 0, -1, 7, 7);       // same target again
    issue(CMD_START, 0, 0, 0, 0, 1, 0);               // mode not continuous
    issue(CMD_START, 0, 0, 0, 0, 15, 15);             // good start
    issue(CMD_START, 0, 0, 0, 0, 1, 3);               // running; stores mode 1
    issue(CMD_STOP, 0, 0, 0, 0, 0, 0);                // stored mode 1 blocks stop
    issue(CMD_START, 0, 0, 0, 0, 2, 9);               // running; stores mode 2
    repeat (4) issue(CMD_TICK, 0, 0, 0, 0, 0, 0);
    issue(CMD_SET, -32768, 32767, 5, 0, 0, 0);        // retarget while running
    repeat (3) issue(CMD_TICK, 0, 0, 0, 0, 0, 0);
    issue(CMD_STOP, 0, 0, 0, 0, 0, 0);
    issue(CMD_TICK, 0, 0, 0, 0, 0, 0);
    issue(CMD_START, 0, 0, 0, 0, 0, 0);               // mode 0 start
    issue(CMD_TICK, 0, 0, 0, 0, 0, 0);
    issue(CMD_STOP, 0, 0, 0, 0, 15, 15);

    // Random part: three idling regimes, each over four kinds of register setting.
    for (int regime = 0; regime < 3; regime++) begin
      case (regime)
        0: begin
          src_idle_pct = 36;
          sink_idle_pct = 79;
        end
        1: begin
          src_idle_pct = 79;
          sink_idle_pct = 36;
        end
        default: begin
          src_idle_pct = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int p = 0; p < 4; p++) begin
        wait_drained();
        choose_settings(limit_style_t'(p));
        // With nobody idling, stall the result side for a long stretch while words
        // keep coming.
        if (regime == 2 && p == 0) hold_request = 1'b1;
        goal = words_sent + BURST_WORDS;
        while (words_sent < goal) begin
          if ($urandom_range(0, 99) < 85) ramp_burst();
          else send_word(random_word(2'($urandom)));
        end
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/fsr_pkg.sv
rtl/fsr_channels.sv
rtl/fsr_lane.sv
rtl/fsr_merge.sv
rtl/four_axis_setpoint_ramp_core.sv
sim/four_axis_setpoint_ramp_checker.sv
sim/four_axis_setpoint_ramp_core_test.sv
